### hw/rtl/sfsp_pkg.sv
// Shared types, constants and helpers for the starfield star projector.
// No dependencies; every other RTL file but sfsp_div imports this package.
`default_nettype none
package sfsp_pkg;

  localparam int IN_IDX_W = 13;
  localparam int RAND_W   = 31;
  localparam int X_W      = 10;
  localparam int Y_W      = 9;
  localparam int Z_W      = 16;

  // Divider geometry: |p| << 14 fits 24 bits, depth fits 16 bits.
  localparam int DIV_N = 24;
  localparam int DIV_D = 16;

  localparam logic MODE_INIT    = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  localparam logic [Z_W-1:0] ONE_Q     = 16'd128;
  localparam logic [Z_W-1:0] RESPAWN_Z = 16'd51200;  // 400.0 in Q9.7

  // floor(2^40 / c): qhat is the quotient or one less.
  localparam logic [31:0] RECIP_400 = 32'd2748779069;
  localparam logic [31:0] RECIP_480 = 32'd2290649224;
  localparam logic [31:0] RECIP_800 = 32'd1374389534;
  // ceil(2^23 / 100), exact for 16-bit depths
  localparam logic [16:0] RECIP_100 = 17'd83887;

  typedef struct packed {
    logic [Z_W-1:0] pz;
    logic [Z_W-1:0] z;
    logic [Y_W-1:0] y;
    logic [X_W-1:0] x;
  } star_t;

  typedef struct packed {
    logic                mode;
    logic [IN_IDX_W-1:0] idx;
    logic [15:0]         speed;
    logic [RAND_W-1:0]   rand_depth;
    logic [RAND_W-1:0]   rand_x;
    logic [RAND_W-1:0]   rand_y;
  } cmd_t;

  typedef struct packed {
    logic       vld;
    logic       neg_x;
    logic       neg_y;
    logic       zero_pz;
    logic       zero_z;
    logic [9:0] zq;
  } side_t;

  // Divide by 128 truncating toward zero.
  function automatic logic signed [35:0] trunc_q7(input logic signed [35:0] p);
    logic signed [35:0] r;
    r = p + (p < 0 ? 36'sd127 : 36'sd0);
    return r >>> 7;
  endfunction

  // Signed quotient plus one half (64 in Q9.7).
  function automatic logic signed [25:0] signed_half(input logic [DIV_N-1:0] q,
                                                     input logic neg, input logic zero);
    logic signed [25:0] s;
    s = signed'({2'b00, q});
    if (zero) s = '0;
    else if (neg) s = -s;
    return s + 26'sd64;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/sfsp_front.sv
// Front end: classifies an item, clamps speed, reduces the star index.
// Depends on sfsp_pkg.
`default_nettype none
module sfsp_front
  import sfsp_pkg::*;
#(
  parameter int STAR_COUNT = 8192
) (
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  mode_i,
  input  wire logic [IN_IDX_W-1:0]   star_index_i,
  input  wire logic signed [16:0]    speed_i,
  input  wire logic [RAND_W-1:0]     rand_depth_i,
  input  wire logic [RAND_W-1:0]     rand_x_i,
  input  wire logic [RAND_W-1:0]     rand_y_i,
  output logic                       cmd_vld_o,
  input  wire logic                  cmd_rdy_i,
  output cmd_t                       cmd_o
);

  logic [IN_IDX_W-1:0] idx_r;

  // index mod STAR_COUNT by conditional subtraction of shifted counts
  always_comb begin
    idx_r = star_index_i;
    for (int k = IN_IDX_W - 1; k >= 0; k--) begin
      if ((STAR_COUNT << k) < (1 << IN_IDX_W)) begin
        if (idx_r >= IN_IDX_W'(STAR_COUNT << k)) begin
          idx_r = idx_r - IN_IDX_W'(STAR_COUNT << k);
        end
      end
    end
  end

  always_comb begin
    cmd_o.mode       = mode_i;
    cmd_o.idx        = idx_r;
    cmd_o.speed      = speed_i[16] ? 16'd0 : speed_i[15:0];
    cmd_o.rand_depth = rand_depth_i;
    cmd_o.rand_x     = rand_x_i;
    cmd_o.rand_y     = rand_y_i;
  end

  assign cmd_vld_o  = in_valid_i;
  assign in_ready_o = cmd_rdy_i;

endmodule
`default_nettype wire

### hw/rtl/sfsp_queue.sv
// Two-entry queue between front end and back end.
// Depends on sfsp_pkg.
`default_nettype none
module sfsp_queue
  import sfsp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_vld_i,
  output logic      push_rdy_o,
  input  cmd_t      push_cmd_i,
  output logic      head_vld_o,
  output cmd_t      head_cmd_o,
  input  wire logic pop_i
);

  localparam int DEPTH = 2;

  cmd_t       ent_q [DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_rdy_o = (cnt_q != 2'(DEPTH));
  assign push       = push_vld_i && push_rdy_o;
  assign pop        = pop_i && head_vld_o;
  assign head_vld_o = (cnt_q != 2'd0);
  assign head_cmd_o = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_ptr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

### hw/rtl/sfsp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// No package dependency.
`default_nettype none
module sfsp_div #(
  parameter int N = 24,
  parameter int D = 16
) (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [N-1:0] num_i,
  input  wire logic [D-1:0] den_i,
  output logic      [N-1:0] quo_o
);

  logic [D-1:0] rem_q [N-1];
  logic [D-1:0] den_q [N-1];
  logic [N-1:0] nq_q  [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [D-1:0] rem_in, den_in;
    logic [N-1:0] nq_in;
    logic [D:0]   trial;
    logic         ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den_i;
      assign nq_in  = num_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign nq_in  = nq_q[s-1];
    end

    assign trial = {rem_in, nq_in[N-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) nq_q[s] <= {nq_in[N-2:0], ge};
    end

    if (s < N - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= ge ? D'(trial - {1'b0, den_in}) : trial[D-1:0];
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign quo_o = nq_q[N-1];

endmodule
`default_nettype wire

### hw/rtl/sfsp_back.sv
// Back end: star memory update, perspective divides, streak output register.
// Depends on sfsp_pkg and sfsp_div.
`default_nettype none
module sfsp_back
  import sfsp_pkg::*;
#(
  parameter int STAR_COUNT = 8192
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               head_vld_i,
  input  cmd_t                    head_cmd_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [18:0]      from_x_o,
  output logic signed [16:0]      from_y_o,
  output logic signed [18:0]      to_x_o,
  output logic signed [16:0]      to_y_o,
  output logic        [1:0]       thickness_o
);

  localparam int AW = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;

  logic en;
  logic out_vld_q;
  assign en    = !out_vld_q || out_ready_i;
  assign pop_o = en && head_vld_i;

  // ---- issue: memory read and reciprocal products
  logic [AW-1:0] head_addr;
  logic [62:0]   pd, px, py;
  assign head_addr = AW'(head_cmd_i.idx);
  assign pd = 63'(head_cmd_i.rand_depth) * 63'(RECIP_400);
  assign px = 63'(head_cmd_i.rand_x) * 63'(RECIP_800);
  assign py = 63'(head_cmd_i.rand_y) * 63'(RECIP_480);

  star_t         mem [STAR_COUNT];
  star_t         rd_q, byp_q, wdata;
  logic          s1_vld_q, s1_mode_q, hit_q;
  logic [AW-1:0] s1_idx_q;
  logic [15:0]   s1_speed_q;
  logic [11:0]   s1_rd_q, s1_rx_q, s1_ry_q, s1_qd_q, s1_qx_q, s1_qy_q;

  // ---- update stage
  logic [11:0]          rem_d, rem_x, rem_y;
  logic [X_W-1:0]       nx;
  logic [Y_W-1:0]       ny;
  logic [Z_W-1:0]       z0, z_new, pz_use;
  logic [X_W-1:0]       x_use;
  logic [Y_W-1:0]       y_use;
  star_t                e;
  logic signed [16:0]   zn;
  logic                 respawn;

  always_comb begin
    // remainders are below twice the divisor, so 12 low bits suffice
    rem_d = s1_rd_q - 12'(s1_qd_q * 12'd400);
    rem_x = s1_rx_q - 12'(s1_qx_q * 12'd800);
    rem_y = s1_ry_q - 12'(s1_qy_q * 12'd480);
    if (rem_d >= 12'd400) rem_d = rem_d - 12'd400;
    if (rem_x >= 12'd800) rem_x = rem_x - 12'd800;
    if (rem_y >= 12'd480) rem_y = rem_y - 12'd480;
    nx = rem_x[X_W-1:0] - 10'd400;
    ny = rem_y[Y_W-1:0] - 9'd240;
    z0 = {rem_d[8:0], 7'd0};

    e       = hit_q ? byp_q : rd_q;
    zn      = signed'({1'b0, e.z}) - signed'({1'b0, s1_speed_q});
    respawn = (zn < signed'({1'b0, ONE_Q}));
    z_new   = respawn ? RESPAWN_Z : zn[15:0];
    pz_use  = respawn ? RESPAWN_Z : e.pz;
    x_use   = respawn ? nx : e.x;
    y_use   = respawn ? ny : e.y;

    if (s1_mode_q == MODE_ADVANCE) begin
      wdata = '{pz: z_new, z: z_new, y: y_use, x: x_use};
    end else begin
      wdata = '{pz: z0, z: z0, y: ny, x: nx};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (s1_vld_q) mem[s1_idx_q] <= wdata;
      if (head_vld_i) rd_q <= mem[head_addr];
      byp_q      <= wdata;
      s1_mode_q  <= head_cmd_i.mode;
      s1_idx_q   <= head_addr;
      s1_speed_q <= head_cmd_i.speed;
      s1_rd_q    <= head_cmd_i.rand_depth[11:0];
      s1_rx_q    <= head_cmd_i.rand_x[11:0];
      s1_ry_q    <= head_cmd_i.rand_y[11:0];
      s1_qd_q    <= pd[51:40];
      s1_qx_q    <= px[51:40];
      s1_qy_q    <= py[51:40];
    end
  end

  // ---- divide setup
  logic                 s2_vld_q;
  logic signed [X_W-1:0] s2_x_q;
  logic signed [Y_W-1:0] s2_y_q;
  logic [Z_W-1:0]       s2_z_q, s2_pz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_x_q  <= signed'(x_use);
      s2_y_q  <= signed'(y_use);
      s2_z_q  <= z_new;
      s2_pz_q <= pz_use;
    end
  end

  logic [X_W-1:0]   mag_x;
  logic [Y_W-1:0]   mag_y;
  logic [DIV_N-1:0] num_x, num_y;
  logic [32:0]      zprod;
  side_t            side_in;
  side_t            side_q [DIV_N];

  assign mag_x = s2_x_q[X_W-1] ? X_W'(-s2_x_q) : X_W'(s2_x_q);
  assign mag_y = s2_y_q[Y_W-1] ? Y_W'(-s2_y_q) : Y_W'(s2_y_q);
  assign num_x = {mag_x, 14'd0};
  assign num_y = {1'b0, mag_y, 14'd0};
  assign zprod = 33'(s2_z_q) * 33'(RECIP_100);

  always_comb begin
    side_in.vld     = s2_vld_q;
    side_in.neg_x   = s2_x_q[X_W-1];
    side_in.neg_y   = s2_y_q[Y_W-1];
    side_in.zero_pz = (s2_pz_q == '0);
    side_in.zero_z  = (s2_z_q == '0);
    side_in.zq      = zprod[32:23];
  end

  logic [DIV_N-1:0] q_fx, q_fy, q_tx, q_ty;

  sfsp_div #(.N(DIV_N), .D(DIV_D)) u_div_fx (
    .clk_i, .en_i(en), .num_i(num_x), .den_i(s2_pz_q), .quo_o(q_fx));
  sfsp_div #(.N(DIV_N), .D(DIV_D)) u_div_fy (
    .clk_i, .en_i(en), .num_i(num_y), .den_i(s2_pz_q), .quo_o(q_fy));
  sfsp_div #(.N(DIV_N), .D(DIV_D)) u_div_tx (
    .clk_i, .en_i(en), .num_i(num_x), .den_i(s2_z_q), .quo_o(q_tx));
  sfsp_div #(.N(DIV_N), .D(DIV_D)) u_div_ty (
    .clk_i, .en_i(en), .num_i(num_y), .den_i(s2_z_q), .quo_o(q_ty));

  // ---- screen scaling
  side_t              sd;
  logic signed [35:0] m_fx, m_fy, m_tx, m_ty;
  logic signed [10:0] tk;
  logic signed [10:0] tk_r;
  logic               p1_vld_q;
  logic signed [35:0] p1_fx_q, p1_fy_q, p1_tx_q, p1_ty_q;
  logic [1:0]         p1_thick_q;

  assign sd   = side_q[DIV_N-1];
  assign m_fx = 36'(signed_half(q_fx, sd.neg_x, sd.zero_pz));
  assign m_fy = 36'(signed_half(q_fy, sd.neg_y, sd.zero_pz));
  assign m_tx = 36'(signed_half(q_tx, sd.neg_x, sd.zero_z));
  assign m_ty = 36'(signed_half(q_ty, sd.neg_y, sd.zero_z));
  assign tk   = 11'sd512 - signed'({1'b0, sd.zq});
  assign tk_r = (tk + (tk < 0 ? 11'sd127 : 11'sd0)) >>> 7;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_fx_q    <= m_fx * 36'sd400;
      p1_fy_q    <= m_fy * 36'sd240;
      p1_tx_q    <= m_tx * 36'sd400;
      p1_ty_q    <= m_ty * 36'sd240;
      p1_thick_q <= tk_r[1:0];
    end
  end

  logic signed [35:0] r_fx, r_fy, r_tx, r_ty;
  assign r_fx = trunc_q7(p1_fx_q);
  assign r_fy = trunc_q7(p1_fy_q);
  assign r_tx = trunc_q7(p1_tx_q);
  assign r_ty = trunc_q7(p1_ty_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      from_x_o    <= r_fx[18:0];
      from_y_o    <= r_fy[16:0];
      to_x_o      <= r_tx[18:0];
      to_y_o      <= r_ty[16:0];
      thickness_o <= p1_thick_q;
    end
  end

  // ---- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      s2_vld_q  <= 1'b0;
      p1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < DIV_N; i++) side_q[i] <= '0;
    end else if (en) begin
      s1_vld_q  <= head_vld_i;
      // the write in flight lands at the same edge as this read
      hit_q     <= s1_vld_q && head_vld_i && (s1_idx_q == head_addr);
      s2_vld_q  <= s1_vld_q && (s1_mode_q == MODE_ADVANCE);
      side_q[0] <= side_in;
      for (int i = 1; i < DIV_N; i++) side_q[i] <= side_q[i-1];
      p1_vld_q  <= sd.vld;
      out_vld_q <= p1_vld_q;
    end
  end

  assign out_valid_o = out_vld_q;

`ifndef SYNTHESIS
  a_hit_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> s1_vld_q)
    else $error("bypass hit without an item in the update stage");
  a_init_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s1_vld_q && s1_mode_q == MODE_INIT) |=> !s2_vld_q)
    else $error("init item went on to the divide stage");
  a_depth_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> (s2_z_q >= ONE_Q))
    else $error("projected depth below one");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(s1_vld_q) && $stable(p1_vld_q) && $stable(s2_vld_q)))
    else $error("pipeline moved during a stall");
`endif

endmodule
`default_nettype wire

### hw/rtl/starfield_star_project_unit.sv
// Top level of the starfield star projector: front end, queue, back end.
// Depends on sfsp_pkg, sfsp_front, sfsp_queue, sfsp_back.
//
//   channel  signals                     direction  payload
//   in       in_valid_i / in_ready_o     input      mode, star_index, speed, rand_*
//   out      out_valid_o / out_ready_i   output     from_x/y, to_x/y, thickness
//
// One item per cycle sustained while the output is not stalled. After its item is
// taken, a streak passes through queue, memory read and update, divide setup,
// 24 divider stages, scaling and output register.
// The four 24-stage dividers set the latency; the star memory has one read and
// one write port, with a bypass for back-to-back access to the same star.
// Reset clears control only; star entries are undefined until initialized.
// A stalled output freezes the whole back end; the queue keeps taking items
// until its two entries are full.
`default_nettype none
module starfield_star_project_unit
  import sfsp_pkg::*;
#(
  parameter int STAR_COUNT = 8192
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               mode_i,
  input  wire logic [12:0]        star_index_i,
  input  wire logic signed [16:0] speed_i,
  input  wire logic [30:0]        rand_depth_i,
  input  wire logic [30:0]        rand_x_i,
  input  wire logic [30:0]        rand_y_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [18:0]      from_x_o,
  output logic signed [16:0]      from_y_o,
  output logic signed [18:0]      to_x_o,
  output logic signed [16:0]      to_y_o,
  output logic        [1:0]       thickness_o
);

  logic cmd_vld, cmd_rdy, head_vld, pop;
  cmd_t cmd, head_cmd;

  sfsp_front #(.STAR_COUNT(STAR_COUNT)) u_front (
    .in_valid_i, .in_ready_o, .mode_i, .star_index_i, .speed_i,
    .rand_depth_i, .rand_x_i, .rand_y_i,
    .cmd_vld_o(cmd_vld), .cmd_rdy_i(cmd_rdy), .cmd_o(cmd));

  sfsp_queue u_queue (
    .clk_i, .rst_ni,
    .push_vld_i(cmd_vld), .push_rdy_o(cmd_rdy), .push_cmd_i(cmd),
    .head_vld_o(head_vld), .head_cmd_o(head_cmd), .pop_i(pop));

  sfsp_back #(.STAR_COUNT(STAR_COUNT)) u_back (
    .clk_i, .rst_ni,
    .head_vld_i(head_vld), .head_cmd_i(head_cmd), .pop_o(pop),
    .out_valid_o, .out_ready_i,
    .from_x_o, .from_y_o, .to_x_o, .to_y_o, .thickness_o);

endmodule
`default_nettype wire

### dv/starfield_checker.sv
// Streak checker for the starfield star projector: watches both channels,
// keeps its own star table, predicts each streak and compares in order.
// Depends on the port list of starfield_star_project_unit and on sfsp_pkg.
`timescale 1ns / 1ps
module starfield_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic               mode_i,
  input  wire logic [12:0]        star_index_i,
  input  wire logic signed [16:0] speed_i,
  input  wire logic [30:0]        rand_depth_i,
  input  wire logic [30:0]        rand_x_i,
  input  wire logic [30:0]        rand_y_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic signed [18:0] from_x_i,
  input  wire logic signed [16:0] from_y_i,
  input  wire logic signed [18:0] to_x_i,
  input  wire logic signed [16:0] to_y_i,
  input  wire logic        [1:0]  thickness_i,
  output int                      fail_cnt_o,
  output int                      pending_o
);
  import sfsp_pkg::*;

  typedef struct packed {
    logic signed [18:0] from_x;
    logic signed [16:0] from_y;
    logic signed [18:0] to_x;
    logic signed [16:0] to_y;
    logic        [1:0]  thick;
  } streak_t;

  longint star_x [8192];
  longint star_y [8192];
  longint star_z [8192];
  longint star_pz[8192];

  streak_t streak_q[$];

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
  end

  function automatic longint proj_pix(longint p, longint d, longint span);
    longint q;
    q = (d != 0) ? (p * 16384) / d : 0;
    return ((q + 64) * span) / 128;
  endfunction

  // Advance one star and return the streak it draws.
  function automatic streak_t advance_star(int idx, longint spd, longint nx, longint ny);
    streak_t s;
    longint  x, y, z, pz;
    x  = star_x[idx];
    y  = star_y[idx];
    z  = star_z[idx];
    pz = star_pz[idx];
    if (spd < 0) spd = 0;
    z -= spd;
    if (z < 128) begin
      z  = 51200;
      x  = nx;
      y  = ny;
      pz = z;
    end
    s.from_x = 19'(proj_pix(x, pz, 400));
    s.from_y = 17'(proj_pix(y, pz, 240));
    s.to_x   = 19'(proj_pix(x, z, 400));
    s.to_y   = 17'(proj_pix(y, z, 240));
    s.thick  = 2'((512 - z / 100) / 128);
    star_x[idx]  = x;
    star_y[idx]  = y;
    star_z[idx]  = z;
    star_pz[idx] = z;
    return s;
  endfunction

  always @(posedge clk_i) begin
    streak_t got, want;
    int      idx;
    longint  nx, ny, zi;
    if (rst_ni && in_valid_i && in_ready_i) begin
      idx = int'(star_index_i);
      nx  = longint'(rand_x_i) % 800 - 400;
      ny  = longint'(rand_y_i) % 480 - 240;
      if (mode_i == MODE_INIT) begin
        zi = (longint'(rand_depth_i) % 400) * 128;
        star_x[idx]  = nx;
        star_y[idx]  = ny;
        star_z[idx]  = zi;
        star_pz[idx] = zi;
      end else begin
        streak_q.push_back(advance_star(idx, longint'(speed_i), nx, ny));
      end
    end
    if (rst_ni && out_valid_i && out_ready_i) begin
      got = '{from_x_i, from_y_i, to_x_i, to_y_i, thickness_i};
      if (streak_q.size() == 0) begin
        fail_cnt_o++;
        if (fail_cnt_o <= 10) $display("unexpected streak %p", got);
      end else begin
        want = streak_q.pop_front();
        if (got !== want) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10) $display("streak mismatch: expected %p got %p", want, got);
        end
      end
    end
    pending_o = streak_q.size();
  end

endmodule

### dv/tb_starfield_star_project_unit.sv
// Testbench top for starfield_star_project_unit: drives stars through init
// and advance items with bursty input and a stalling output; starfield_checker judges.
`timescale 1ns / 1ps
module tb_starfield_star_project_unit;
  import sfsp_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               mode_i = MODE_INIT;
  logic [12:0]        star_index_i = '0;
  logic signed [16:0] speed_i = '0;
  logic [30:0]        rand_depth_i = '0;
  logic [30:0]        rand_x_i = '0;
  logic [30:0]        rand_y_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [18:0] from_x_o;
  logic signed [16:0] from_y_o;
  logic signed [18:0] to_x_o;
  logic signed [16:0] to_y_o;
  logic        [1:0]  thickness_o;
  int                 fail_cnt;
  int                 pending;

  bit star_live[8192];
  bit hold_req = 1'b0;
  bit stim_done = 1'b0;

  starfield_star_project_unit uut (.*);

  starfield_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .mode_i, .star_index_i,
    .speed_i, .rand_depth_i, .rand_x_i, .rand_y_i, .out_valid_i(out_valid_o),
    .out_ready_i, .from_x_i(from_x_o), .from_y_i(from_y_o), .to_x_i(to_x_o),
    .to_y_i(to_y_o), .thickness_i(thickness_o), .fail_cnt_o(fail_cnt),
    .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("tb_starfield_star_project_unit NOT OK");
    $finish;
  end

  // Offer one item and hold it until taken.
  task automatic send_item(logic m, logic [12:0] idx, logic signed [16:0] spd,
                           logic [30:0] rd, logic [30:0] rx, logic [30:0] ry);
    @(negedge clk_i);
    in_valid_i   = 1'b1;
    mode_i       = m;
    star_index_i = idx;
    speed_i      = spd;
    rand_depth_i = rd;
    rand_x_i     = rx;
    rand_y_i     = ry;
    if (m == MODE_INIT) star_live[idx] = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic idle_gap(int n);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  function automatic logic [12:0] pick_index();
    int k;
    k = $urandom_range(0, 47);
    return (k < 40) ? 13'(k) : 13'(8191 - (k - 40));
  endfunction

  function automatic logic signed [16:0] pick_speed();
    case ($urandom_range(0, 9))
      0, 1, 2: return 17'($urandom);
      3, 4, 5, 6: return 17'($urandom_range(0, 2000));
      default: return 17'($urandom_range(0, 65535));
    endcase
  endfunction

  // Receiver: switches between randomly chosen stall patterns; honors long hold-offs.
  initial begin
    int mode_sel;
    int cnt;
    cnt = 0;
    mode_sel = 0;
    while (1) begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (300) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (cnt == 0) begin
        mode_sel = $urandom_range(0, 2);
        cnt = $urandom_range(10, 60);
      end
      cnt--;
      case (mode_sel)
        0: out_ready_i = 1'b1;
        1: out_ready_i = 1'($urandom_range(0, 1));
        default: out_ready_i = ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  initial begin
    logic [12:0] idx;
    int burst;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: depth extremes, index extremes, speed extremes, respawn edge
    send_item(MODE_INIT, 13'd0, 17'sd0, 31'd0, 31'd0, 31'd0);
    send_item(MODE_ADVANCE, 13'd0, 17'sd0, 31'd0, 31'd799, 31'd479);
    send_item(MODE_INIT, 13'd8191, 17'sd0, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
    send_item(MODE_ADVANCE, 13'd8191, 17'sh10000, 31'd0, 31'd0, 31'd0);
    send_item(MODE_ADVANCE, 13'd8191, 17'sd65535, 31'd5, 31'd0, 31'd0);
    send_item(MODE_INIT, 13'd1, 17'sd0, 31'd1, 31'd799, 31'd0);
    send_item(MODE_ADVANCE, 13'd1, 17'sd0, 31'd0, 31'd0, 31'd0);
    send_item(MODE_ADVANCE, 13'd1, 17'sd1, 31'd0, 31'd400, 31'd240);
    send_item(MODE_INIT, 13'd2, 17'sd0, 31'd399, 31'd0, 31'd479);
    send_item(MODE_ADVANCE, 13'd2, 17'sd128, 31'd0, 31'd0, 31'd0);
    send_item(MODE_ADVANCE, 13'd2, 17'sd128, 31'd0, 31'd0, 31'd0);
    send_item(MODE_INIT, 13'd3, 17'sd0, 31'd100, 31'd1, 31'd1);
    send_item(MODE_ADVANCE, 13'd3, 17'sd1, 31'd0, 31'd0, 31'd0);
    idle_gap(1);
    wait (pending == 0);

    for (int n = 0; n < 900; ) begin
      burst = $urandom_range(1, 30);
      for (int b = 0; b < burst && n < 900; b++, n++) begin
        if (n == 300) hold_req = 1'b1;
        if (n == 600) begin
          idle_gap(1);
          wait (pending == 0);
        end
        idx = pick_index();
        if (!star_live[idx] || $urandom_range(0, 5) == 0) begin
          if ($urandom_range(0, 7) == 0) idx = 13'($urandom);
          send_item(MODE_INIT, idx, 17'($urandom), 31'($urandom), 31'($urandom),
                    31'($urandom));
        end else begin
          send_item(MODE_ADVANCE, idx, pick_speed(), 31'($urandom), 31'($urandom),
                    31'($urandom));
        end
      end
      idle_gap($urandom_range(0, 6));
    end
    wait (pending == 0);
    repeat (60) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb_starfield_star_project_unit OK");
    end else begin
      $display("tb_starfield_star_project_unit NOT OK");
    end
    $finish;
  end

endmodule
